// File: src/msb_first_bit_reader_defines.svh
// Assertion macros for the MSB-first bit reader.
// Each module that uses them has clk and arst_n in scope.
`ifndef MSB_FIRST_BIT_READER_DEFINES_SVH
`define MSB_FIRST_BIT_READER_DEFINES_SVH

// same-cycle implication, off during reset
`define MFBR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mfbr assertion failed");

// next-cycle implication, off during reset
`define MFBR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mfbr assertion failed");

`endif

// File: src/mfbr_pkg.sv
// Shared types and constants of the MSB-first bit reader.
// No dependencies; imported by every module of the block.
`default_nettype none

package mfbr_pkg;

	localparam int STORE_BYTES_DEF  = 64;
	localparam int MAX_GET_BITS_DEF = 64;
	localparam int BANK_BITS        = 4;
	localparam int NBANK            = 1 << BANK_BITS;
	localparam int CQ_DEPTH         = 2;
	localparam int RQ_DEPTH         = 4;
	localparam int RQ_CBITS         = $clog2(RQ_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_PUSH    = 2'd0,
		CMD_GET     = 2'd1,
		CMD_SKIP    = 2'd2,
		CMD_RESTART = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t        op;
		logic [7:0]  data;
		logic [11:0] amount;
	} item_t;

	typedef struct packed {
		logic [63:0] value;
		logic [6:0]  got;
		logic [9:0]  remaining;
		logic        shortage;
		logic        accepted;
	} result_t;

endpackage

`default_nettype wire

// File: src/mfbr_front.sv
// Front part: accepts beats, classifies the command, saturates get counts
// and holds them in a short command queue. Depends on mfbr_pkg.
`default_nettype none
`include "msb_first_bit_reader_defines.svh"

module mfbr_front import mfbr_pkg::*; #(
	parameter int MAX_GET_BITS = MAX_GET_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  cmd,
	input  logic [7:0]  data_byte,
	input  logic [11:0] count,
	output logic        item_valid,
	output item_t       item,
	input  logic        item_pop
);

	localparam int PBITS = $clog2(CQ_DEPTH);

	item_t            ent_q [CQ_DEPTH];
	logic [PBITS-1:0] wr_ptr_q;
	logic [PBITS-1:0] rd_ptr_q;
	logic [PBITS:0]   cnt_q;
	item_t            cls;
	logic             take;

	always_comb begin
		cls.op     = cmd_t'(cmd);
		cls.data   = data_byte;
		cls.amount = count;
		if (cls.op == CMD_GET && count > 12'(MAX_GET_BITS)) begin
			cls.amount = 12'(MAX_GET_BITS);
		end
	end

	assign full       = (cnt_q == (PBITS+1)'(CQ_DEPTH));
	assign take       = push && !full;
	assign item_valid = (cnt_q != '0);
	assign item       = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (take) begin
				wr_ptr_q <= wr_ptr_q + PBITS'(1);
			end
			if (item_pop) begin
				rd_ptr_q <= rd_ptr_q + PBITS'(1);
			end
			if (take && !item_pop) begin
				cnt_q <= cnt_q + (PBITS+1)'(1);
			end else if (!take && item_pop) begin
				cnt_q <= cnt_q - (PBITS+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	`MFBR_ASSERT_IMP(a_pop_needs_item, item_pop, cnt_q != '0)

endmodule

`default_nettype wire

// File: src/mfbr_back.sv
// Back part: read position state, banked byte store and bit extraction.
// Executes one command a cycle while result credit allows; depends on mfbr_pkg.
`default_nettype none
`include "msb_first_bit_reader_defines.svh"

module mfbr_back import mfbr_pkg::*; #(
	parameter int STORE_BYTES  = STORE_BYTES_DEF,
	parameter int MAX_GET_BITS = MAX_GET_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  item_t               item,
	output logic                item_pop,
	input  logic [RQ_CBITS-1:0] rq_cnt,
	output logic                res_valid,
	output result_t             res
);

	localparam int ABITS     = (STORE_BYTES > 32) ? $clog2(STORE_BYTES) : 5;
	localparam int RBITS     = ABITS - BANK_BITS;
	localparam int ROWS      = 1 << RBITS;
	localparam int CBITS     = $clog2(STORE_BYTES + 1);
	localparam int AVBITS    = CBITS + 3;
	localparam int CW        = (AVBITS > 12) ? AVBITS : 12;
	localparam int WIN_BYTES = (MAX_GET_BITS + 14) / 8;
	localparam int WBITS     = WIN_BYTES * 8;
	localparam int SHBITS    = $clog2(WBITS + 1);

	logic [ABITS-1:0]     head_q;
	logic [CBITS-1:0]     cnt_q;
	logic [2:0]           off_q;
	logic                 short_q;

	logic                 fire;
	logic [AVBITS-1:0]    avail;
	logic [CW-1:0]        amt_w;
	logic [CW-1:0]        avail_w;
	logic                 lack;
	logic [CW-1:0]        take;
	logic [CW:0]          total;
	logic [CW-3:0]        adv;
	logic                 store_full;
	logic [ABITS-1:0]     wr_addr;
	logic                 we;
	logic                 rd_en;

	logic [ABITS-1:0]     head_n;
	logic [CBITS-1:0]     cnt_n;
	logic [2:0]           off_n;
	logic                 short_n;
	logic                 acc_n;
	logic [6:0]           got_n;
	logic [AVBITS-1:0]    av_n;
	logic [SHBITS-1:0]    sh_n;

	logic                 valid_s2;
	logic [BANK_BITS-1:0] hlo_s2;
	logic [SHBITS-1:0]    sh_s2;
	logic [6:0]           got_s2;
	logic [9:0]           rem_s2;
	logic                 short_s2;
	logic                 acc_s2;
	logic [7:0]           rd_data_s2 [NBANK];
	logic [WBITS-1:0]     win;

	assign fire = item_valid &&
		((RQ_CBITS+1)'(rq_cnt) + (RQ_CBITS+1)'(valid_s2) < (RQ_CBITS+1)'(RQ_DEPTH));
	assign item_pop = fire;

	assign avail      = {cnt_q, 3'b000} - AVBITS'(off_q);
	assign amt_w      = CW'(item.amount);
	assign avail_w    = CW'(avail);
	assign lack       = (amt_w > avail_w);
	assign take       = lack ? avail_w : amt_w;
	assign total      = (CW+1)'(off_q) + (CW+1)'(take);
	assign adv        = total[CW:3];
	assign store_full = (cnt_q == CBITS'(STORE_BYTES));
	assign wr_addr    = head_q + ABITS'(cnt_q);
	assign we         = fire && item.op == CMD_PUSH && !store_full;
	assign rd_en      = fire && item.op == CMD_GET;

	always_comb begin
		head_n  = head_q;
		cnt_n   = cnt_q;
		off_n   = off_q;
		short_n = short_q;
		acc_n   = 1'b1;
		got_n   = '0;
		case (item.op)
			CMD_PUSH: begin
				if (store_full) begin
					acc_n = 1'b0;
				end else begin
					cnt_n = cnt_q + CBITS'(1);
				end
			end
			CMD_GET: begin
				head_n  = head_q + ABITS'(adv);
				cnt_n   = cnt_q - CBITS'(adv);
				off_n   = total[2:0];
				short_n = short_q | lack;
				got_n   = 7'(take);
			end
			CMD_SKIP: begin
				head_n  = head_q + ABITS'(adv);
				cnt_n   = cnt_q - CBITS'(adv);
				off_n   = total[2:0];
				short_n = short_q | lack;
			end
			CMD_RESTART: begin
				head_n  = '0;
				cnt_n   = '0;
				off_n   = '0;
				short_n = 1'b0;
			end
			default: begin
				acc_n = 1'b1;
			end
		endcase
	end

	assign av_n = {cnt_n, 3'b000} - AVBITS'(off_n);
	assign sh_n = SHBITS'(WBITS) - SHBITS'(off_q) - SHBITS'(got_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			cnt_q    <= '0;
			off_q    <= '0;
			short_q  <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= fire;
			if (fire) begin
				head_q  <= head_n;
				cnt_q   <= cnt_n;
				off_q   <= off_n;
				short_q <= short_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hlo_s2   <= head_q[BANK_BITS-1:0];
			sh_s2    <= sh_n;
			got_s2   <= got_n;
			rem_s2   <= 10'(av_n);
			short_s2 <= short_n;
			acc_s2   <= acc_n;
		end
	end

	for (genvar b = 0; b < NBANK; b++) begin : g_bank
		logic [7:0]       mem_q [ROWS];
		logic [RBITS-1:0] rd_row;

		assign rd_row = head_q[ABITS-1:BANK_BITS] +
			RBITS'(BANK_BITS'(b) < head_q[BANK_BITS-1:0]);

		always_ff @(posedge clk) begin
			if (we && wr_addr[BANK_BITS-1:0] == BANK_BITS'(b)) begin
				mem_q[wr_addr[ABITS-1:BANK_BITS]] <= item.data;
			end
			if (rd_en) begin
				rd_data_s2[b] <= mem_q[rd_row];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < WIN_BYTES; j++) begin
			win[WBITS-1-8*j -: 8] = rd_data_s2[BANK_BITS'(hlo_s2 + BANK_BITS'(j))];
		end
	end

	assign res_valid     = valid_s2;
	assign res.value     = 64'(win >> sh_s2) & ~({64{1'b1}} << got_s2);
	assign res.got       = got_s2;
	assign res.remaining = rem_s2;
	assign res.shortage  = short_s2;
	assign res.accepted  = acc_s2;

	`MFBR_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CBITS'(STORE_BYTES))
	`MFBR_ASSERT_IMP(a_empty_aligned, cnt_q == '0, off_q == 3'd0)
	`MFBR_ASSERT_NEXT(a_restart_clears, fire && item.op == CMD_RESTART, cnt_q == '0 && !short_q)

endmodule

`default_nettype wire

// File: src/mfbr_resq.sv
// Result queue: holds finished result beats until the receiver pops them.
// Reports its fill level to the back part as credit. Depends on mfbr_pkg.
`default_nettype none
`include "msb_first_bit_reader_defines.svh"

module mfbr_resq import mfbr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  result_t             wdata,
	output logic [RQ_CBITS-1:0] level,
	output logic                empty,
	input  logic                pop,
	output result_t             rdata
);

	localparam int PBITS = $clog2(RQ_DEPTH);

	result_t             ent_q [RQ_DEPTH];
	logic [PBITS-1:0]    wr_ptr_q;
	logic [PBITS-1:0]    rd_ptr_q;
	logic [RQ_CBITS-1:0] cnt_q;
	logic                rd;

	assign empty = (cnt_q == '0);
	assign rd    = pop && !empty;
	assign level = cnt_q;
	assign rdata = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + PBITS'(1);
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + PBITS'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + RQ_CBITS'(1);
			end else if (!wr && rd) begin
				cnt_q <= cnt_q - RQ_CBITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wr_ptr_q] <= wdata;
		end
	end

	`MFBR_ASSERT_IMP(a_no_overflow, wr, cnt_q < RQ_CBITS'(RQ_DEPTH))

endmodule

`default_nettype wire

// File: src/msb_first_bit_reader.sv
// MSB-first bit reader, top level: front classifier, back executor, result queue.
// Depends on mfbr_pkg, mfbr_front, mfbr_back and mfbr_resq.
//
// Usage: the command side is a queue write port (push, full); one beat carries
// cmd, data_byte and count. cmd pushes a byte, gets up to MAX_GET_BITS bits
// (64 by default) MSB-first, skips bits or restarts the stream. The result
// side is a queue read port (empty, pop); every command gives exactly one
// result beat, in order. A command passes the command queue, the back part's
// registers and the result queue. Throughput: one command per cycle while
// the result queue has room; a get reads one row from each of the sixteen
// byte banks of the store at once and registers the next position with it.
// Reset: the store is empty, position and shortage flag clear, both queues
// empty. The store needs no clearing pass.
// Stall: while pop is low, results collect in a four-beat queue; the back
// part then holds, the two-beat command queue fills and full rises.
`default_nettype none

module msb_first_bit_reader import mfbr_pkg::*; #(
	parameter int STORE_BYTES  = STORE_BYTES_DEF,
	parameter int MAX_GET_BITS = MAX_GET_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  cmd,
	input  logic [7:0]  data_byte,
	input  logic [11:0] count,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] bits_value,
	output logic [6:0]  bits_got,
	output logic [9:0]  bits_remaining,
	output logic        shortage,
	output logic        accepted
);

	logic                item_valid;
	item_t               item;
	logic                item_pop;
	logic [RQ_CBITS-1:0] rq_level;
	logic                res_valid;
	result_t             res;
	result_t             rq_data;

	mfbr_front #(
		.MAX_GET_BITS(MAX_GET_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.cmd        (cmd),
		.data_byte  (data_byte),
		.count      (count),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	mfbr_back #(
		.STORE_BYTES  (STORE_BYTES),
		.MAX_GET_BITS (MAX_GET_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.rq_cnt     (rq_level),
		.res_valid  (res_valid),
		.res        (res)
	);

	mfbr_resq u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_valid),
		.wdata  (res),
		.level  (rq_level),
		.empty  (empty),
		.pop    (pop),
		.rdata  (rq_data)
	);

	assign bits_value     = rq_data.value;
	assign bits_got       = rq_data.got;
	assign bits_remaining = rq_data.remaining;
	assign shortage       = rq_data.shortage;
	assign accepted       = rq_data.accepted;

endmodule

`default_nettype wire
